// ===== hdl/hqs_pkg.sv =====
// Shared types, widths, codes and packing helpers of the histogram quantile selector.
`timescale 1ns / 1ps

package hqs_pkg;

  // Field widths
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned SumW    = 42;
  localparam int unsigned DblW    = 33;
  localparam int unsigned KW      = 6;
  localparam int unsigned ErrW    = 2;
  localparam int unsigned TgtW    = SumW + 1;

  // Stream bus widths
  localparam int unsigned InDataW     = ValueW + CountW;
  localparam int unsigned OutFieldsW  = KW + DblW + SumW + ErrW;
  localparam int unsigned OutDataW    = ((OutFieldsW + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam logic RegInterval = 1'b0;
  localparam logic RegAveraged = 1'b1;
  localparam logic [KW-1:0] IntervalReset = KW'(4);
  localparam logic          AveragedReset = 1'b1;

  // Error codes
  localparam logic [ErrW-1:0] ErrNone        = ErrW'(0);
  localparam logic [ErrW-1:0] ErrZeroTotal   = ErrW'(1);
  localparam logic [ErrW-1:0] ErrTooManyBins = ErrW'(2);

  // Configuration seen by the datapath
  typedef struct packed {
    logic [KW-1:0] interval_count;
    logic          averaged_steps;
  } cfg_t;

  // Divider result
  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quo;
    logic [KW-1:0]   rem;
  } div_res_t;

  // Pack one result, first field in the lowest bits
  function automatic logic [OutDataW-1:0] pack_result(
    input logic [KW-1:0]   k,
    input logic [DblW-1:0] dbl,
    input logic [SumW-1:0] tot,
    input logic [ErrW-1:0] err
  );
    logic [OutDataW-1:0] w;
    w = '0;
    w[KW-1:0]                            = k;
    w[KW+DblW-1:KW]                      = dbl;
    w[KW+DblW+SumW-1:KW+DblW]            = tot;
    w[KW+DblW+SumW+ErrW-1:KW+DblW+SumW]  = err;
    return w;
  endfunction

endpackage

// ===== hdl/hqs_cfg.sv =====
// APB register file holding the interval count and the mode select.
`timescale 1ns / 1ps

module hqs_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hqs_pkg::PaddrW-1:0] paddr,
  input  logic [hqs_pkg::PdataW-1:0] pwdata,
  output logic [hqs_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output hqs_pkg::cfg_t              cfg_o
);
  import hqs_pkg::*;

  logic [KW-1:0] interval_q;
  logic          averaged_q;
  logic          wr_en;
  logic          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
      averaged_q <= AveragedReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegInterval: interval_q <= pwdata[KW-1:0];
        RegAveraged: averaged_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      RegInterval: prdata = {{(PdataW-KW){1'b0}}, interval_q};
      RegAveraged: prdata = {{(PdataW-1){1'b0}}, averaged_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.interval_count = interval_q;
  assign cfg_o.averaged_steps = averaged_q;

endmodule

// ===== hdl/hqs_bin_store.sv =====
// Value and cumulative count memories, one write and one registered read port each.
`timescale 1ns / 1ps

module hqs_bin_store #(
  parameter  int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [hqs_pkg::ValueW-1:0] wr_value_i,
  input  logic [hqs_pkg::SumW-1:0]   wr_cum_i,
  input  logic                       val_rd_en_i,
  input  logic [AddrW-1:0]           val_rd_addr_i,
  output logic [hqs_pkg::ValueW-1:0] val_rd_data_o,
  input  logic                       cum_rd_en_i,
  input  logic [AddrW-1:0]           cum_rd_addr_i,
  output logic [hqs_pkg::SumW-1:0]   cum_rd_data_o
);
  import hqs_pkg::*;

  logic [ValueW-1:0] val_mem [Depth];
  logic [SumW-1:0]   cum_mem [Depth];
  logic [ValueW-1:0] val_rd_q;
  logic [SumW-1:0]   cum_rd_q;

  // Value memory; read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      val_mem[wr_addr_i] <= wr_value_i;
    end
    if (val_rd_en_i) begin
      val_rd_q <= val_mem[val_rd_addr_i];
    end
  end

  // Cumulative count memory
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      cum_mem[wr_addr_i] <= wr_cum_i;
    end
    if (cum_rd_en_i) begin
      cum_rd_q <= cum_mem[cum_rd_addr_i];
    end
  end

  assign val_rd_data_o = val_rd_q;
  assign cum_rd_data_o = cum_rd_q;

endmodule

// ===== hdl/hqs_div.sv =====
// Bit-serial restoring divider: total count by interval count, one quotient bit a cycle.
`timescale 1ns / 1ps

module hqs_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [hqs_pkg::SumW-1:0] dividend_i,
  input  logic [hqs_pkg::KW-1:0]   divisor_i,
  output hqs_pkg::div_res_t        res_o
);
  import hqs_pkg::*;

  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [SumW-1:0] dvd_q;
  logic [SumW-1:0] quo_q;
  logic [KW-1:0]   rem_q;
  logic [KW:0]     trial;
  logic            ge;

  // Partial remainder with the next dividend bit shifted in
  assign trial = {rem_q, dvd_q[SumW-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  // Iterate one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      dvd_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      cnt_q  <= CntW'(SumW);
      busy_q <= 1'b1;
      done_q <= 1'b0;
      dvd_q  <= dividend_i;
      quo_q  <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? KW'(trial - {1'b0, divisor_i}) : trial[KW-1:0];
      quo_q <= {quo_q[SumW-2:0], ge};
      dvd_q <= {dvd_q[SumW-2:0], 1'b0};
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.quo  = quo_q;
  assign res_o.rem  = rem_q;

endmodule

// ===== hdl/histogram_quantile_select.sv =====
// Top level: bin loading, rank walk sequencer and result register.
//
// Channel   Dir  Handshake                  Payload (lowest bits first)
// s_axis    in   tvalid/tready              tdata: bin_value[31:0], bin_count[63:32];
//                                           tlast: last_bin
// m_axis    out  tvalid/tready              tdata: quantile_number[5:0],
//                                           quantile_doubled[38:6], total_count[80:39],
//                                           error_code[82:81], zeros; tlast: last_result
// apb       in   psel/penable/pwrite/pready interval_count at 0x0, averaged_steps at 0x4
//
// Bins load at one per cycle into the value and cumulative memories while in S_LOAD.
// After the last bin quantile 0 goes out during the serial divide; then each interior
// quantile steps the rank and walks the cumulative memory toward its target;
// every walk reads at least once and the pointer only moves forward.
// Reset clears the bin count, running sum and overflow flag; memories stay undefined.
// A stalled result stops the sequencer; the next histogram loads while the final one waits.
`timescale 1ns / 1ps

module histogram_quantile_select #(
  parameter int unsigned MAX_BINS      = 1024,
  parameter int unsigned MAX_INTERVALS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // bin stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [hqs_pkg::InDataW-1:0]  s_axis_tdata,   // bin_value, bin_count
  input  logic                         s_axis_tlast,
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // quantile_number, quantile_doubled, total_count, error_code
  output logic [hqs_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hqs_pkg::PaddrW-1:0]   paddr,
  input  logic [hqs_pkg::PdataW-1:0]   pwdata,
  output logic [hqs_pkg::PdataW-1:0]   prdata,
  output logic                         pready
);
  import hqs_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_BINS);
  localparam int unsigned CntW  = $clog2(MAX_BINS + 1);
  localparam logic [KW-1:0] MaxQ = KW'(MAX_INTERVALS);

  typedef enum logic [3:0] {
    S_LOAD,
    S_ERR,
    S_V0_RD,
    S_V0_PUT,
    S_DIV_WAIT,
    S_STEP,
    S_TGT,
    S_WALK_RD,
    S_WALK_CMP,
    S_VRD,
    S_VCAP,
    S_VL_RD,
    S_VL_PUT
  } state_e;

  state_e state_q;

  cfg_t     cfg;
  div_res_t div_res;

  logic [CntW-1:0]     bin_total_q;
  logic [SumW-1:0]     sum_q;
  logic                ovf_q;
  logic [SumW-1:0]     n_q;
  logic [KW-1:0]       q_q;
  logic                avg_q;
  logic [KW-1:0]       k_q;
  logic [SumW-1:0]     quo_q;
  logic [KW-1:0]       rem_q;
  logic [AddrW-1:0]    rank_q;
  logic [TgtW-1:0]     target_q;
  logic                phase_q;
  logic [ValueW-1:0]   v1_q;
  logic [ErrW-1:0]     err_q;
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic                m_last_q;

  logic [ValueW-1:0] in_value;
  logic [CountW-1:0] in_count;
  logic              s_accept;
  logic              store_full;
  logic [SumW-1:0]   sum_new;
  logic [KW-1:0]     q_clamp;
  logic              out_free;
  logic              result_load;
  logic              div_start;
  logic [CntW-1:0]   last_idx;
  logic              val_rd_en;
  logic [AddrW-1:0]  val_rd_addr;
  logic              cum_rd_en;
  logic [ValueW-1:0] val_rd;
  logic [SumW-1:0]   cum_rd;
  logic              walk_adv;
  logic [KW:0]       r_sum;
  logic              r_wrap;
  logic              round_up;
  logic              ceil_up;
  logic [TgtW-1:0]   tgt_first;
  logic [DblW-1:0]   dbl_val;
  logic [DblW-1:0]   dbl_mid;
  logic              more_mid;

  assign in_value = s_axis_tdata[ValueW-1:0];
  assign in_count = s_axis_tdata[ValueW+CountW-1:ValueW];

  assign s_axis_tready = (state_q == S_LOAD);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign store_full    = bin_total_q >= CntW'(MAX_BINS);
  assign sum_new       = sum_q + SumW'(in_count);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign last_idx      = bin_total_q - CntW'(1);

  // Clamp the interval count into its legal range
  always_comb begin
    if (cfg.interval_count == '0) begin
      q_clamp = KW'(1);
    end else if (cfg.interval_count > MaxQ) begin
      q_clamp = MaxQ;
    end else begin
      q_clamp = cfg.interval_count;
    end
  end

  // Load the result register in the states that emit a transaction
  always_comb begin
    result_load = 1'b0;
    case (state_q)
      S_ERR, S_V0_PUT, S_VL_PUT: result_load = out_free;
      S_VCAP:                    result_load = out_free && !(avg_q && !phase_q);
      default: ;
    endcase
  end

  // Memory read selection
  assign cum_rd_en = (state_q == S_WALK_RD);
  always_comb begin
    val_rd_en   = 1'b0;
    val_rd_addr = rank_q;
    case (state_q)
      S_V0_RD: begin
        val_rd_en   = 1'b1;
        val_rd_addr = '0;
      end
      S_VRD: begin
        val_rd_en   = 1'b1;
        val_rd_addr = rank_q;
      end
      S_VL_RD: begin
        val_rd_en   = 1'b1;
        val_rd_addr = last_idx[AddrW-1:0];
      end
      default: ;
    endcase
  end

  assign div_start = (state_q == S_V0_RD);

  // Rank step: add n/q to the running quotient and remainder
  assign r_sum  = {1'b0, rem_q} + {1'b0, div_res.rem};
  assign r_wrap = r_sum >= {1'b0, q_q};

  // First walk target: round half up or ceiling of k*n/q
  assign round_up  = {rem_q, 1'b0} >= {1'b0, q_q};
  assign ceil_up   = rem_q != '0;
  assign tgt_first = {1'b0, quo_q} + TgtW'(avg_q ? round_up : ceil_up);

  // Advance while a further bin exists and the current bin's cumulative count is short of the target
  assign walk_adv = ((CntW'(rank_q) + CntW'(1)) < bin_total_q) &&
                    (target_q > {1'b0, cum_rd});

  // Doubled quantile values
  assign dbl_val  = {val_rd, 1'b0};
  assign dbl_mid  = avg_q ? ({v1_q[ValueW-1], v1_q} + {val_rd[ValueW-1], val_rd}) : dbl_val;
  assign more_mid = ({1'b0, k_q} + (KW+1)'(1)) < {1'b0, q_q};

  // Sequencer, histogram state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      bin_total_q <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      q_q         <= KW'(1);
      avg_q       <= 1'b0;
      k_q         <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      rank_q      <= '0;
      target_q    <= '0;
      phase_q     <= 1'b0;
      v1_q        <= '0;
      err_q       <= ErrNone;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      m_last_q    <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once taken
      if (result_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_LOAD: begin
          if (s_accept) begin
            sum_q <= sum_new;
            if (store_full) begin
              ovf_q <= 1'b1;
            end else begin
              bin_total_q <= bin_total_q + CntW'(1);
            end
            if (s_axis_tlast) begin
              n_q     <= sum_new;
              q_q     <= q_clamp;
              avg_q   <= cfg.averaged_steps;
              k_q     <= '0;
              quo_q   <= '0;
              rem_q   <= '0;
              rank_q  <= '0;
              phase_q <= 1'b0;
              err_q   <= (ovf_q || store_full) ? ErrTooManyBins : ErrZeroTotal;
              if (ovf_q || store_full || sum_new == '0) begin
                state_q <= S_ERR;
              end else begin
                state_q <= S_V0_RD;
              end
            end
          end
        end

        S_ERR: begin
          if (out_free) begin
            m_data_q    <= pack_result('0, '0, n_q, err_q);
            m_last_q    <= 1'b1;
            bin_total_q <= '0;
            sum_q       <= '0;
            ovf_q       <= 1'b0;
            state_q     <= S_LOAD;
          end
        end

        S_V0_RD: begin
          state_q <= S_V0_PUT;
        end

        S_V0_PUT: begin
          if (out_free) begin
            m_data_q  <= pack_result('0, dbl_val, n_q, ErrNone);
            m_last_q  <= 1'b0;
            state_q   <= (q_q == KW'(1)) ? S_VL_RD : S_DIV_WAIT;
          end
        end

        S_DIV_WAIT: begin
          if (div_res.done) begin
            state_q <= S_STEP;
          end
        end

        S_STEP: begin
          k_q     <= k_q + KW'(1);
          quo_q   <= quo_q + div_res.quo + SumW'(r_wrap);
          rem_q   <= r_wrap ? KW'(r_sum - {1'b0, q_q}) : r_sum[KW-1:0];
          state_q <= S_TGT;
        end

        S_TGT: begin
          target_q <= tgt_first;
          phase_q  <= 1'b0;
          state_q  <= S_WALK_RD;
        end

        S_WALK_RD: begin
          state_q <= S_WALK_CMP;
        end

        S_WALK_CMP: begin
          if (walk_adv) begin
            rank_q  <= rank_q + AddrW'(1);
            state_q <= S_WALK_RD;
          end else begin
            state_q <= S_VRD;
          end
        end

        S_VRD: begin
          state_q <= S_VCAP;
        end

        S_VCAP: begin
          if (avg_q && !phase_q) begin
            // Hold the rounded-rank value and walk on to floor plus one
            v1_q     <= val_rd;
            phase_q  <= 1'b1;
            target_q <= {1'b0, quo_q} + TgtW'(1);
            state_q  <= S_WALK_RD;
          end else if (out_free) begin
            m_data_q  <= pack_result(k_q, dbl_mid, n_q, ErrNone);
            m_last_q  <= 1'b0;
            state_q   <= more_mid ? S_STEP : S_VL_RD;
          end
        end

        S_VL_RD: begin
          state_q <= S_VL_PUT;
        end

        S_VL_PUT: begin
          if (out_free) begin
            m_data_q    <= pack_result(q_q, dbl_val, n_q, ErrNone);
            m_last_q    <= 1'b1;
            bin_total_q <= '0;
            sum_q       <= '0;
            ovf_q       <= 1'b0;
            state_q     <= S_LOAD;
          end
        end

        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  hqs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hqs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (q_q),
    .res_o      (div_res)
  );

  hqs_bin_store #(
    .Depth (MAX_BINS)
  ) u_store (
    .clk_i         (clk_i),
    .wr_en_i       (s_accept && !store_full),
    .wr_addr_i     (bin_total_q[AddrW-1:0]),
    .wr_value_i    (in_value),
    .wr_cum_i      (sum_new),
    .val_rd_en_i   (val_rd_en),
    .val_rd_addr_i (val_rd_addr),
    .val_rd_data_o (val_rd),
    .cum_rd_en_i   (cum_rd_en),
    .cum_rd_addr_i (rank_q),
    .cum_rd_data_o (cum_rd)
  );

endmodule

// ===== sim/histogram_quantile_select_test.sv =====
// Self-checking testbench for the histogram quantile selector.
`timescale 1ns / 1ps

module histogram_quantile_select_test;
  import hqs_pkg::*;

  localparam int unsigned BinDepth    = 1024;
  localparam int unsigned IntervalMax = 32;
  localparam int unsigned LongHold    = 800;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit  = 500000;

  // Receiver stall patterns
  typedef enum int {RxSteady, RxCoin, RxSparse, RxPeriodic} rx_mode_e;

  // One quantile result as it leaves the block
  typedef struct packed {
    logic [KW-1:0]   number;
    logic [DblW-1:0] doubled;
    logic [SumW-1:0] total;
    logic [ErrW-1:0] err;
    logic            is_last;
  } quantile_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // bin_value, bin_count
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // quantile_number, quantile_doubled,
                                             // total_count, error_code, zeros
  logic                m_axis_tlast;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [PaddrW-1:0]   paddr         = '0;
  logic [PdataW-1:0]   pwdata        = '0;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  histogram_quantile_select #(
    .MAX_BINS      (BinDepth),
    .MAX_INTERVALS (IntervalMax)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: stored bins, running sum and register shadows
  logic [ValueW-1:0] bin_values [BinDepth];
  logic [SumW-1:0]   bin_cumsum [BinDepth];
  int unsigned       stored_bins    = 0;
  logic [SumW-1:0]   count_sum      = '0;
  logic              store_overflow = 1'b0;
  logic [KW-1:0]     interval_reg   = IntervalReset;
  logic              averaged_reg   = AveragedReset;

  quantile_t   pending_quantiles [$];
  int          error_count  = 0;
  int unsigned burst_left   = 0;
  bit          sender_steady = 1'b0;
  bit          hold_pending = 1'b0;
  bit          hold_active  = 1'b0;

  // Histogram under construction, sent by send_histogram
  int          hist_values [$];
  logic [31:0] hist_counts [$];

  function automatic quantile_t make_quantile(input logic [KW-1:0] k,
                                              input logic [DblW-1:0] d,
                                              input logic [SumW-1:0] tot,
                                              input logic [ErrW-1:0] err,
                                              input logic is_last);
    quantile_t q;
    q.number  = k;
    q.doubled = d;
    q.total   = tot;
    q.err     = err;
    q.is_last = is_last;
    return q;
  endfunction

  // Append one expected quantile at the tail of the queue
  function automatic void expect_quantile(input quantile_t qt);
    pending_quantiles.insert(pending_quantiles.size(), qt);
  endfunction

  function automatic logic [DblW-1:0] widen(input logic [ValueW-1:0] v);
    return {v[ValueW-1], v};
  endfunction

  // Advance the rank pointer until the cumulative count reaches the target
  function automatic int unsigned advance_rank(input int unsigned r, input logic [63:0] target);
    while (r + 1 < stored_bins && target > 64'(bin_cumsum[r])) r++;
    return r;
  endfunction

  // Store one bin and, on the last bin, queue the quantiles it yields
  task automatic predict_quantiles(input logic [ValueW-1:0] v, input logic [CountW-1:0] c,
                                   input logic is_last);
    logic [63:0]    n;
    logic [63:0]    q;
    logic [63:0]    kn;
    logic [DblW-1:0] d;
    int unsigned    rank;
    int unsigned    r1;
    count_sum = count_sum + SumW'(c);
    if (stored_bins < BinDepth) begin
      bin_values[stored_bins] = v;
      bin_cumsum[stored_bins] = count_sum;
      stored_bins++;
    end else begin
      store_overflow = 1'b1;
    end
    if (!is_last) return;
    n = 64'(count_sum);
    if (store_overflow || n == 0) begin
      expect_quantile(make_quantile('0, '0, count_sum,
          store_overflow ? ErrTooManyBins : ErrZeroTotal, 1'b1));
    end else begin
      q = 64'(interval_reg);
      if (q == 0) q = 1;
      if (q > IntervalMax) q = IntervalMax;
      expect_quantile(make_quantile('0, {bin_values[0], 1'b0}, count_sum,
                                    ErrNone, 1'b0));
      rank = 0;
      for (int k = 1; k < q; k++) begin
        kn = 64'(k) * n;
        if (averaged_reg) begin
          r1   = advance_rank(rank, (2 * kn + q) / (2 * q));
          rank = advance_rank(r1, kn / q + 1);
          d = widen(bin_values[r1]) + widen(bin_values[rank]);
        end else begin
          rank = advance_rank(rank, (kn + q - 1) / q);
          d = {bin_values[rank], 1'b0};
        end
        expect_quantile(make_quantile(KW'(k), d, count_sum, ErrNone, 1'b0));
      end
      expect_quantile(make_quantile(KW'(q), {bin_values[stored_bins - 1], 1'b0},
                                    count_sum, ErrNone, 1'b1));
    end
    stored_bins    = 0;
    count_sum      = '0;
    store_overflow = 1'b0;
  endtask

  // Offer one bin, with a random gap between bursts; returns after the accepting edge
  task automatic send_bin(input logic [ValueW-1:0] v, input logic [CountW-1:0] c,
                          input logic is_last);
    int unsigned gap;
    if (!sender_steady && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      s_axis_tlast  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, v};
    s_axis_tlast  <= is_last;
    do @(negedge clk_i); while (!s_axis_tready);
    predict_quantiles(v, c, is_last);
    @(posedge clk_i);
  endtask

  task automatic send_histogram();
    for (int i = 0; i < hist_values.size(); i++)
      send_bin(hist_values[i], hist_counts[i], i == hist_values.size() - 1);
    hist_values.delete();
    hist_counts.delete();
  endtask

  task automatic add_bin(input int v, input logic [31:0] c);
    hist_values.insert(hist_values.size(), v);
    hist_counts.insert(hist_counts.size(), c);
  endtask

  // Wait for every expected quantile, then let the block settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_quantiles.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  // Write one register through setup and access, then read it back
  task automatic config_write(input logic idx, input logic [PdataW-1:0] data);
    logic [PdataW-1:0] readback;
    readback = (idx == RegInterval) ? PdataW'(data[KW-1:0]) : PdataW'(data[0]);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == RegInterval) interval_reg = data[KW-1:0];
    else averaged_reg = data[0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== readback) begin
      $display("%0t: register %0d readback expected %0h got %0h",
               $time, idx, readback, prdata);
      error_count++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(input logic [KW-1:0] intervals, input logic averaged);
    logic [PdataW-1:0] data;
    data = $urandom;
    data[KW-1:0] = intervals;
    config_write(RegInterval, data);
    data = $urandom;
    data[0] = averaged;
    config_write(RegAveraged, data);
  endtask

  function automatic logic [31:0] random_count(input int style);
    case (style)
      0:       return 32'($urandom_range(0, 3));
      1:       return 32'($urandom_range(0, 20));
      2:       return $urandom;
      3:       return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(0, 1000));
    endcase
  endfunction

  // Build a random histogram: mostly ascending values, some unsorted or empty
  task automatic make_random_histogram();
    int    nbins;
    int    shape;
    int    style;
    int    base;
    int    vals [$];
    shape = $urandom_range(0, 9);
    style = $urandom_range(0, 4);
    nbins = (shape == 2) ? 1 : (shape == 3) ? $urandom_range(11, 60) : $urandom_range(2, 10);
    base  = $urandom;
    for (int i = 0; i < nbins; i++) begin
      if (style == 2) vals.insert(vals.size(), $urandom);
      else vals.insert(vals.size(), base + $urandom_range(0, 200) - 100);
    end
    if (shape != 1) vals.sort();
    foreach (vals[i])
      add_bin(vals[i], (shape == 0) ? 32'd0 : random_count($urandom_range(0, 1) ? style : 4));
  endtask

  task automatic test_directed_extremes();
    // single bin at the top of both ranges
    add_bin(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_histogram();
    // extreme values with an empty bin in the middle
    add_bin(32'h8000_0000, 32'd1);
    add_bin(0, 32'd0);
    add_bin(32'h7FFF_FFFF, 32'd5);
    send_histogram();
    // zero total
    add_bin(5, 32'd0);
    add_bin(6, 32'd0);
    send_histogram();
    // bins out of order
    add_bin(10, 32'd3);
    add_bin(-5, 32'd7);
    add_bin(100, 32'd2);
    add_bin(-100, 32'd1);
    send_histogram();
    wait_drained();
  endtask

  // Interval count at and beyond its limits in both modes
  task automatic test_config_extremes();
    logic [KW-1:0] ivl [6];
    logic          avg [6];
    ivl = '{KW'(1), KW'(32), KW'(32), KW'(0), KW'(63), KW'(2)};
    avg = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    for (int i = 0; i < 6; i++) begin
      set_mode(ivl[i], avg[i]);
      add_bin(32'h8000_0000, 32'd1);
      add_bin(-1, 32'd2);
      add_bin(32'h7FFF_FFFF, 32'd1);
      send_histogram();
      wait_drained();
    end
  endtask

  // Hold the result side for a long stretch while bins keep coming
  task automatic test_result_stall();
    set_mode(KW'(32), 1'b1);
    hold_pending = 1'b1;
    wait (hold_active);
    sender_steady = 1'b1;
    for (int h = 0; h < 4; h++) begin
      for (int i = 0; i < 8; i++) add_bin(h * 100 + i, random_count(4));
      send_histogram();
    end
    sender_steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_histograms();
    int phase_items;
    logic [KW-1:0] ivl;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 7))
        0:       ivl = KW'(1);
        1:       ivl = KW'(32);
        2:       ivl = KW'(0);
        3:       ivl = KW'($urandom_range(33, 63));
        default: ivl = KW'($urandom_range(2, 31));
      endcase
      set_mode(ivl, 1'($urandom_range(0, 1)));
      phase_items = 0;
      while (phase_items < 26) begin
        make_random_histogram();
        phase_items += hist_values.size();
        sender_steady = ($urandom_range(0, 3) == 0);
        send_histogram();
      end
      sender_steady = 1'b0;
      wait_drained();
    end
  endtask

  // Result side: its own stall pattern, or a long hold on request
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    mode      = RxSteady;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_active  = 1'b1;
        hold_left    = LongHold;
      end
      if (hold_active) begin
        m_axis_tready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_active = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RxSteady:   m_axis_tready <= 1'b1;
          RxCoin:     m_axis_tready <= 1'($urandom_range(0, 1));
          RxSparse:   m_axis_tready <= ($urandom_range(0, 3) == 0);
          RxPeriodic: m_axis_tready <= (tick % 5 != 0);
          default:    m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  // Compare each result transaction with the oldest expected quantile
  always @(negedge clk_i) begin
    quantile_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_quantiles.size() == 0) begin
        $display("%0t: result %0h with none expected", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_quantiles.pop_front();
        compare_field("quantile_number", 64'(want.number), 64'(m_axis_tdata[KW-1:0]));
        compare_field("quantile_doubled", 64'(want.doubled),
                      64'(m_axis_tdata[KW+DblW-1:KW]));
        compare_field("total_count", 64'(want.total),
                      64'(m_axis_tdata[KW+DblW+SumW-1:KW+DblW]));
        compare_field("error_code", 64'(want.err),
                      64'(m_axis_tdata[KW+DblW+SumW+ErrW-1:KW+DblW+SumW]));
        compare_field("last_result", 64'(want.is_last), 64'(m_axis_tlast));
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("histogram_quantile_select_test: errors");
    $finish;
  end

  initial begin : sequencer
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_config_extremes();
    test_result_stall();
    test_random_histograms();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && pending_quantiles.size() == 0) begin
      $display("histogram_quantile_select_test: clean");
    end else begin
      $display("histogram_quantile_select_test: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hqs_pkg.sv
hdl/hqs_cfg.sv
hdl/hqs_bin_store.sv
hdl/hqs_div.sv
hdl/histogram_quantile_select.sv
sim/histogram_quantile_select_test.sv
